[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/bblc_pkg.sv]
// ----------------------------------------------------------------------------
// bblc_pkg
// Types and constants shared by the LRU cache bookkeeping core.
// ----------------------------------------------------------------------------
`default_nettype none
package bblc_pkg;
    localparam int STAMP_W    = 64;
    localparam int SIZE_W     = 29;
    localparam int GEN_W      = 32;
    localparam int BYTES_W    = 33;
    localparam int LIMIT_W    = 32;
    localparam int ELIM_W     = 12;
    localparam int OUT_CNT_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RESET  = 32'd268435456;
    localparam logic [ELIM_W-1:0]  ENTRY_LIMIT_RESET = 12'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_BYTE_LIMIT  = 2'd1,
        CFG_ENTRY_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_GCLEAR,
        S_LOOKUP,
        S_UPDATE,
        S_TRIM_CHK,
        S_FIND_OLD,
        S_EVICT,
        S_DONE
    } t_state;

    typedef enum logic {
        SCAN_LOOKUP,
        SCAN_OLDEST
    } t_scan_mode;

    typedef struct packed {
        logic       start;
        logic       step;
        t_scan_mode mode;
    } t_scan_ctl;

    typedef struct packed {
        logic match;
        logic free;
        logic old;
    } t_scan_flags;
endpackage
`default_nettype wire

[hdl/bblc_ifs.sv]
// ----------------------------------------------------------------------------
// bblc_ifs
// Valid/ready channels of the cache core: access, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none
interface bblc_in_if #(parameter int KEY_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [KEY_BITS-1:0]           entry_key;
    logic                          table_select;
    logic [bblc_pkg::GEN_W-1:0]    generation;
    logic [bblc_pkg::SIZE_W-1:0]   entry_bytes;
    modport source (output valid, kind, entry_key, table_select, generation,
                    entry_bytes, input ready);
    modport sink (input valid, kind, entry_key, table_select, generation,
                  entry_bytes, output ready);
endinterface

interface bblc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [bblc_pkg::OUT_CNT_W-1:0] evicted_count;
    logic                           new_entry_evicted;
    logic [bblc_pkg::BYTES_W-1:0]   bytes_held;
    logic [bblc_pkg::OUT_CNT_W-1:0] entries_held;
    modport source (output valid, hit, evicted_count, new_entry_evicted, bytes_held,
                    entries_held, input ready);
    modport sink (input valid, hit, evicted_count, new_entry_evicted, bytes_held,
                  entries_held, output ready);
endinterface

interface bblc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bblc_pkg::CFG_IDX_W-1:0]  index;
    logic [bblc_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/byte_budget_lru_two_table_cache_core.sv]
// ----------------------------------------------------------------------------
// byte_budget_lru_two_table_cache_core
// LRU bookkeeping for a two-table cache bounded in bytes and entry count.
// ----------------------------------------------------------------------------
// Timing: all work runs through one record memory and one compare unit that
// visit a single slot per cycle, over MAX_ENTRIES + 1 slots. After reset the
// store is swept empty before the first access is taken. A lookup pass visits
// every slot; a hit then goes through the update step to the result. A miss
// adds a trim check and, per evicted entry, an oldest-entry pass over every
// slot and another trim check. A clear item or a generation change costs an
// extra sweep of the store. With caching disabled an access goes straight to
// the result. One item is worked on at a time; the result sits in an output
// register, and the next access is taken once that register has been loaded.
`default_nettype none
`include "assert_macros.svh"
module byte_budget_lru_two_table_cache_core #(
    parameter int MAX_ENTRIES = 2048,
    parameter int KEY_BITS    = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bblc_in_if.sink      i_in,
    bblc_out_if.source   o_out,
    bblc_cfg_if.sink     i_cfg
);
    localparam int SLOTS = MAX_ENTRIES + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int CTRW  = $clog2(SLOTS + 1);
    localparam int CW    = $clog2(MAX_ENTRIES + 2);
    localparam int LW    = (CW > bblc_pkg::ELIM_W) ? CW : bblc_pkg::ELIM_W;
    localparam int TW    = KEY_BITS + 1;
    localparam int RW    = 1 + TW + bblc_pkg::STAMP_W + bblc_pkg::SIZE_W;
    localparam logic [CTRW-1:0] LAST_SLOT = CTRW'(SLOTS - 1);
    localparam logic [CTRW-1:0] SCAN_END  = CTRW'(SLOTS);
    localparam logic [LW-1:0]   MAX_LIM   = LW'(MAX_ENTRIES);

    bblc_pkg::t_state                r_state, n_state;
    logic [CTRW-1:0]                 r_addr;
    logic                            r_enable;
    logic [bblc_pkg::LIMIT_W-1:0]    r_byte_limit;
    logic [bblc_pkg::ELIM_W-1:0]     r_entry_limit;
    logic [bblc_pkg::GEN_W-1:0]      r_cur_gen;
    logic [bblc_pkg::STAMP_W-1:0]    r_age;
    logic [bblc_pkg::BYTES_W-1:0]    r_total;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_evicted;
    logic                            r_hit;
    logic                            r_new_gone;
    logic [AW-1:0]                   r_slot;
    logic                            r_slot_ok;
    logic                            r_kind;
    logic [TW-1:0]                   r_tag;
    logic [bblc_pkg::SIZE_W-1:0]     r_bytes;
    logic [bblc_pkg::GEN_W-1:0]      r_gen;

    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [bblc_pkg::OUT_CNT_W-1:0]  r_out_evicted;
    logic                            r_out_new_gone;
    logic [bblc_pkg::BYTES_W-1:0]    r_out_bytes;
    logic [bblc_pkg::OUT_CNT_W-1:0]  r_out_entries;

    logic                            in_xfer;
    logic                            out_free;
    logic                            sweep_last;
    logic                            scan_last;
    logic                            trim_need;
    logic [LW-1:0]                   lim;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [RW-1:0]                   mem_wdata;
    logic [AW-1:0]                   mem_raddr;
    logic [RW-1:0]                   mem_rdata;
    bblc_pkg::t_scan_ctl             scan_ctl;
    bblc_pkg::t_scan_flags           scan_flags;
    logic [AW-1:0]                   match_idx;
    logic [bblc_pkg::SIZE_W-1:0]     match_size;
    logic [AW-1:0]                   free_idx;
    logic [AW-1:0]                   old_idx;
    logic [bblc_pkg::SIZE_W-1:0]     old_size;
    logic [CTRW-1:0]                 scan_pos;

    // record layout: valid | tag | stamp | size
    bblc_store #(.DEPTH(SLOTS), .AW(AW), .RW(RW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bblc_scan #(.AW(AW), .TW(TW)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_idx        (scan_pos[AW-1:0]),
        .i_valid      (mem_rdata[RW-1]),
        .i_tag        (mem_rdata[RW-2 -: TW]),
        .i_stamp      (mem_rdata[bblc_pkg::SIZE_W +: bblc_pkg::STAMP_W]),
        .i_size       (mem_rdata[bblc_pkg::SIZE_W-1:0]),
        .i_ref_tag    (r_tag),
        .o_flags      (scan_flags),
        .o_match_idx  (match_idx),
        .o_match_size (match_size),
        .o_free_idx   (free_idx),
        .o_old_idx    (old_idx),
        .o_old_size   (old_size)
    );

    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign sweep_last = (r_addr == LAST_SLOT);
    assign scan_last  = (r_addr == SCAN_END);
    assign scan_pos   = r_addr - CTRW'(1);
    assign lim        = (LW'(r_entry_limit) > MAX_LIM) ? MAX_LIM : LW'(r_entry_limit);
    assign trim_need  = (r_total > {1'b0, r_byte_limit}) || (LW'(r_count) > lim);
    assign mem_raddr  = (r_addr < SCAN_END) ? r_addr[AW-1:0] : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bblc_pkg::S_INIT: begin
                if (sweep_last) n_state = bblc_pkg::S_IDLE;
            end
            bblc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.kind) begin
                        n_state = bblc_pkg::S_CLEAR;
                    end else if (!r_enable) begin
                        n_state = bblc_pkg::S_DONE;
                    end else if (i_in.generation != r_cur_gen) begin
                        n_state = bblc_pkg::S_GCLEAR;
                    end else begin
                        n_state = bblc_pkg::S_LOOKUP;
                    end
                end
            end
            bblc_pkg::S_CLEAR: begin
                if (sweep_last) n_state = bblc_pkg::S_DONE;
            end
            bblc_pkg::S_GCLEAR: begin
                if (sweep_last) n_state = bblc_pkg::S_LOOKUP;
            end
            bblc_pkg::S_LOOKUP: begin
                if (scan_last) n_state = bblc_pkg::S_UPDATE;
            end
            bblc_pkg::S_UPDATE: begin
                n_state = scan_flags.match ? bblc_pkg::S_DONE : bblc_pkg::S_TRIM_CHK;
            end
            bblc_pkg::S_TRIM_CHK: begin
                n_state = trim_need ? bblc_pkg::S_FIND_OLD : bblc_pkg::S_DONE;
            end
            bblc_pkg::S_FIND_OLD: begin
                if (scan_last) n_state = bblc_pkg::S_EVICT;
            end
            bblc_pkg::S_EVICT: begin
                n_state = scan_flags.old ? bblc_pkg::S_TRIM_CHK : bblc_pkg::S_DONE;
            end
            bblc_pkg::S_DONE: begin
                if (out_free) n_state = bblc_pkg::S_IDLE;
            end
            default: n_state = bblc_pkg::S_INIT;
        endcase
    end

    // control outputs
    always_comb begin
        mem_we         = 1'b0;
        mem_waddr      = r_addr[AW-1:0];
        mem_wdata      = '0;
        scan_ctl.start = 1'b0;
        scan_ctl.step  = 1'b0;
        scan_ctl.mode  = bblc_pkg::SCAN_OLDEST;
        i_in.ready     = 1'b0;
        case (r_state)
            bblc_pkg::S_INIT, bblc_pkg::S_CLEAR: begin
                mem_we = 1'b1;
            end
            bblc_pkg::S_GCLEAR: begin
                mem_we         = 1'b1;
                scan_ctl.start = 1'b1;
            end
            bblc_pkg::S_IDLE: begin
                i_in.ready     = 1'b1;
                scan_ctl.start = 1'b1;
            end
            bblc_pkg::S_LOOKUP: begin
                scan_ctl.mode = bblc_pkg::SCAN_LOOKUP;
                scan_ctl.step = (r_addr != '0);
            end
            bblc_pkg::S_FIND_OLD: begin
                scan_ctl.step = (r_addr != '0);
            end
            bblc_pkg::S_TRIM_CHK: begin
                scan_ctl.start = 1'b1;
            end
            bblc_pkg::S_UPDATE: begin
                if (scan_flags.match) begin
                    mem_we    = 1'b1;
                    mem_waddr = match_idx;
                    mem_wdata = {1'b1, r_tag, r_age + 64'd1, match_size};
                end else if (scan_flags.free) begin
                    mem_we    = 1'b1;
                    mem_waddr = free_idx;
                    mem_wdata = {1'b1, r_tag, r_age + 64'd1, r_bytes};
                end
            end
            bblc_pkg::S_EVICT: begin
                mem_we    = scan_flags.old;
                mem_waddr = old_idx;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // configuration port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_byte_limit  <= bblc_pkg::BYTE_LIMIT_RESET;
            r_entry_limit <= bblc_pkg::ENTRY_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bblc_pkg::CFG_ENABLE:      r_enable      <= i_cfg.data[0];
                bblc_pkg::CFG_BYTE_LIMIT:  r_byte_limit  <= i_cfg.data;
                bblc_pkg::CFG_ENTRY_LIMIT: r_entry_limit <= i_cfg.data[bblc_pkg::ELIM_W-1:0];
                default:                   r_enable      <= r_enable;
            endcase
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind  <= i_in.kind;
            r_tag   <= {i_in.table_select, i_in.entry_key};
            r_bytes <= i_in.entry_bytes;
            r_gen   <= i_in.generation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bblc_pkg::S_INIT;
            r_addr     <= '0;
            r_cur_gen  <= '0;
            r_age      <= '0;
            r_total    <= '0;
            r_count    <= '0;
            r_evicted  <= '0;
            r_hit      <= 1'b0;
            r_new_gone <= 1'b0;
            r_slot     <= '0;
            r_slot_ok  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                bblc_pkg::S_INIT, bblc_pkg::S_CLEAR, bblc_pkg::S_GCLEAR: begin
                    r_addr <= sweep_last ? '0 : r_addr + CTRW'(1);
                    if (sweep_last) begin
                        r_total <= '0;
                        r_count <= '0;
                    end
                    if (r_state == bblc_pkg::S_GCLEAR && sweep_last) begin
                        r_cur_gen <= r_gen;
                    end
                end
                bblc_pkg::S_IDLE: begin
                    r_addr     <= '0;
                    r_evicted  <= '0;
                    r_hit      <= 1'b0;
                    r_new_gone <= 1'b0;
                    r_slot_ok  <= 1'b0;
                end
                bblc_pkg::S_LOOKUP, bblc_pkg::S_FIND_OLD: begin
                    r_addr <= scan_last ? '0 : r_addr + CTRW'(1);
                end
                bblc_pkg::S_UPDATE: begin
                    if (scan_flags.match) begin
                        r_hit <= 1'b1;
                        r_age <= r_age + 64'd1;
                    end else if (scan_flags.free) begin
                        r_age     <= r_age + 64'd1;
                        r_total   <= r_total + bblc_pkg::BYTES_W'(r_bytes);
                        r_count   <= r_count + CW'(1);
                        r_slot    <= free_idx;
                        r_slot_ok <= 1'b1;
                    end
                end
                bblc_pkg::S_EVICT: begin
                    if (scan_flags.old) begin
                        r_total   <= r_total - bblc_pkg::BYTES_W'(old_size);
                        r_count   <= r_count - CW'(1);
                        r_evicted <= r_evicted + CW'(1);
                        if (r_slot_ok && old_idx == r_slot) r_new_gone <= 1'b1;
                    end
                end
                default: begin
                    r_addr <= '0;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == bblc_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bblc_pkg::S_DONE && out_free) begin
            r_out_hit      <= r_hit;
            r_out_evicted  <= bblc_pkg::OUT_CNT_W'(r_evicted);
            r_out_new_gone <= r_new_gone;
            r_out_bytes    <= r_total;
            r_out_entries  <= bblc_pkg::OUT_CNT_W'(r_count);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.hit               = r_out_hit;
    assign o_out.evicted_count     = r_out_evicted;
    assign o_out.new_entry_evicted = r_out_new_gone;
    assign o_out.bytes_held        = r_out_bytes;
    assign o_out.entries_held      = r_out_entries;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(SLOTS))
    `ASSERT_IMPLIES(a_hit_no_evict, i_clk, i_rst_n, r_state == bblc_pkg::S_DONE && r_hit, r_evicted == '0 && !r_new_gone)
    `ASSERT_IMPLIES(a_evict_nonempty, i_clk, i_rst_n, r_state == bblc_pkg::S_EVICT && scan_flags.old, r_count != '0 && r_total >= bblc_pkg::BYTES_W'(old_size))
    `ASSERT_IMPLIES(a_clear_empties, i_clk, i_rst_n, r_state == bblc_pkg::S_DONE && r_kind, r_count == '0 && r_total == '0)
endmodule
`default_nettype wire

[hdl/bblc_store.sv]
// ----------------------------------------------------------------------------
// bblc_store
// Entry record memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module bblc_store #(
    parameter int DEPTH = 2049,
    parameter int AW    = 12,
    parameter int RW    = 120
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [RW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [RW-1:0] o_rdata
);
    logic [RW-1:0] r_mem [DEPTH];
    logic [RW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[hdl/bblc_scan.sv]
// ----------------------------------------------------------------------------
// bblc_scan
// Shared compare unit: one stored record per cycle, tracking the first tag
// match and first free slot, or the oldest valid entry.
// ----------------------------------------------------------------------------
`default_nettype none
module bblc_scan #(
    parameter int AW = 12,
    parameter int TW = 25
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bblc_pkg::t_scan_ctl           i_ctl,
    input  wire logic [AW-1:0]                 i_idx,
    input  wire logic                          i_valid,
    input  wire logic [TW-1:0]                 i_tag,
    input  wire logic [bblc_pkg::STAMP_W-1:0]  i_stamp,
    input  wire logic [bblc_pkg::SIZE_W-1:0]   i_size,
    input  wire logic [TW-1:0]                 i_ref_tag,
    output bblc_pkg::t_scan_flags              o_flags,
    output logic [AW-1:0]                      o_match_idx,
    output logic [bblc_pkg::SIZE_W-1:0]        o_match_size,
    output logic [AW-1:0]                      o_free_idx,
    output logic [AW-1:0]                      o_old_idx,
    output logic [bblc_pkg::SIZE_W-1:0]        o_old_size
);
    bblc_pkg::t_scan_flags           r_flags;
    logic [AW-1:0]                   r_match_idx;
    logic [bblc_pkg::SIZE_W-1:0]     r_match_size;
    logic [AW-1:0]                   r_free_idx;
    logic [AW-1:0]                   r_old_idx;
    logic [bblc_pkg::SIZE_W-1:0]     r_old_size;
    logic [bblc_pkg::STAMP_W-1:0]    r_old_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_flags <= '0;
        end else if (i_ctl.step) begin
            case (i_ctl.mode)
                bblc_pkg::SCAN_LOOKUP: begin
                    if (i_valid && i_tag == i_ref_tag && !r_flags.match) begin
                        r_flags.match <= 1'b1;
                        r_match_idx   <= i_idx;
                        r_match_size  <= i_size;
                    end
                    if (!i_valid && !r_flags.free) begin
                        r_flags.free <= 1'b1;
                        r_free_idx   <= i_idx;
                    end
                end
                bblc_pkg::SCAN_OLDEST: begin
                    // strict compare keeps the lowest slot on equal stamps
                    if (i_valid && (!r_flags.old || i_stamp < r_old_stamp)) begin
                        r_flags.old <= 1'b1;
                        r_old_idx   <= i_idx;
                        r_old_size  <= i_size;
                        r_old_stamp <= i_stamp;
                    end
                end
                default: begin
                    r_flags <= r_flags;
                end
            endcase
        end
    end

    assign o_flags      = r_flags;
    assign o_match_idx  = r_match_idx;
    assign o_match_size = r_match_size;
    assign o_free_idx   = r_free_idx;
    assign o_old_idx    = r_old_idx;
    assign o_old_size   = r_old_size;
endmodule
`default_nettype wire
